@@ sv/ipi_pkg.sv @@
`default_nettype none
package ipi_pkg;

  localparam int FracBits   = 16;
  localparam int ScaleFrac  = 24;
  localparam int QuatFrac   = 14;
  localparam int ScaleShift = ScaleFrac - FracBits;
  localparam int MaxDtMs    = 65535;

  localparam logic [2:0] REG_ACC_SCALE = 3'd0;
  localparam logic [2:0] REG_GRAV_X    = 3'd1;
  localparam logic [2:0] REG_GRAV_Y    = 3'd2;
  localparam logic [2:0] REG_GRAV_Z    = 3'd3;
  localparam logic [2:0] REG_STILL     = 3'd4;

  localparam logic [23:0]        AccScaleRst = 24'd10036;
  localparam logic signed [21:0] GravXRst    = 22'sd0;
  localparam logic signed [21:0] GravYRst    = 22'sd0;
  localparam logic signed [21:0] GravZRst    = 22'sd642689;
  localparam logic [20:0]        StillRst    = 21'd39322;

  localparam logic signed [16:0] KBlendLo = 17'sd33;
  localparam logic signed [16:0] KBlendHi = 17'sd66;

  localparam logic [12:0] DenBlend = 13'd100;
  localparam logic [12:0] DenHalf  = 13'd2000;
  localparam logic [12:0] DenFull  = 13'd1000;
  localparam logic [12:0] DenSixth = 13'd6000;

  localparam int          RecipShift = 29;
  localparam logic [22:0] RecipBlend = 23'd5368709;
  localparam logic [22:0] RecipHalf  = 23'd268435;
  localparam logic [22:0] RecipFull  = 23'd536870;
  localparam logic [22:0] RecipSixth = 23'd89478;

  typedef enum logic [2:0] {
    T_IDLE, T_SCALE, T_ROT, T_UPD, T_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    ROT_IDLE, ROT_T, ROT_TRND, ROT_R, ROT_RRND
  } rot_state_t;

  typedef enum logic [3:0] {
    L_IDLE, L_SMUL, L_SRND, L_ACC, L_SQ, L_MUL, L_DLD, L_DIV, L_WB
  } lane_state_t;

  typedef enum logic [2:0] {
    JOB_A2, JOB_A3, JOB_V2, JOB_V3, JOB_V4, JOB_POS, JOB_VEL
  } job_t;

  typedef struct packed {
    logic        scale_go;
    logic        upd_go;
    logic        started;
    logic [15:0] ms;
  } lane_cmd_t;

  typedef struct packed {
    logic scl_done;
    logic upd_done;
  } lane_stat_t;

  function automatic logic signed [63:0] rsh_rnd(input logic signed [63:0] v,
                                                 input int unsigned sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) return 48'sh7FFF_FFFF_FFFF;
    else if (v < -64'sd140737488355328) return 48'sh8000_0000_0000;
    else return v[47:0];
  endfunction

  function automatic logic [12:0] job_den(input job_t j);
    unique case (j)
      JOB_A2, JOB_A3:   return DenBlend;
      JOB_V2, JOB_V3:   return DenHalf;
      JOB_V4:           return DenFull;
      default:          return DenSixth;
    endcase
  endfunction

  function automatic logic [22:0] job_recip(input job_t j);
    unique case (j)
      JOB_A2, JOB_A3:   return RecipBlend;
      JOB_V2, JOB_V3:   return RecipHalf;
      JOB_V4:           return RecipFull;
      default:          return RecipSixth;
    endcase
  endfunction

  function automatic job_t job_after(input job_t j);
    unique case (j)
      JOB_A2:  return JOB_A3;
      JOB_A3:  return JOB_V2;
      JOB_V2:  return JOB_V3;
      JOB_V3:  return JOB_V4;
      JOB_V4:  return JOB_POS;
      JOB_POS: return JOB_VEL;
      default: return JOB_A2;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ sv/ipi_lane.sv @@
`default_nettype none
module ipi_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  ipi_pkg::lane_cmd_t       cmd,
  input  logic signed [15:0]       raw,
  input  logic [23:0]              scale,
  input  logic signed [21:0]       grav,
  input  logic signed [31:0]       rot,
  output ipi_pkg::lane_stat_t      stat,
  output logic signed [31:0]       a_scl,
  output logic [63:0]              sq,
  output logic signed [47:0]       pos
);

  ipi_pkg::lane_state_t state, state_next;
  ipi_pkg::job_t        job;
  logic [2:0]           cnt;
  logic signed [40:0]   prod_s;
  logic signed [65:0]   prod;
  logic signed [31:0]   last_accel, diff, drive;
  logic signed [33:0]   a2, a3;
  logic signed [47:0]   v2, v3, v4, vel;
  logic [63:0]          nmag, quot;
  logic [12:0]          rem;
  logic [15:0]          qest;
  logic                 neg;

  logic signed [31:0]   acc_now, diff_now;
  logic [31:0]          dmag;
  logic signed [47:0]   vs;
  logic signed [63:0]   as_sum, qs;
  logic signed [48:0]   op_a;
  logic signed [16:0]   op_b;
  logic signed [65:0]   prod_full, pabs;
  logic [12:0]          den;
  logic [22:0]          recip;
  logic [28:0]          dx, dr;
  logic [44:0]          dprod;
  logic [15:0]          qe, qd;
  logic [12:0]          rd;

  always_comb begin
    acc_now  = ipi_pkg::sat32(64'(rot) - 64'(grav));
    diff_now = ipi_pkg::sat32(64'(acc_now) - 64'(last_accel));
    dmag     = diff[31] ? 32'(-diff) : 32'(diff);
    vs       = ipi_pkg::sat48(64'(vel) + 64'(v2) + 64'(v2) + 64'(v3) + 64'(v3) + 64'(v4));
    as_sum   = 64'(drive) + 64'(a2) + 64'(a2) + 64'(a3) + 64'(a3) + 64'(diff);
    case (job)
      ipi_pkg::JOB_A2, ipi_pkg::JOB_A3: op_a = 49'(64'(diff) - 64'(drive));
      ipi_pkg::JOB_V2:  op_a = 49'(drive);
      ipi_pkg::JOB_V3:  op_a = 49'(a2);
      ipi_pkg::JOB_V4:  op_a = 49'(a3);
      ipi_pkg::JOB_POS: op_a = 49'(vs);
      default:          op_a = as_sum[48:0];
    endcase
    case (job)
      ipi_pkg::JOB_A2: op_b = ipi_pkg::KBlendLo;
      ipi_pkg::JOB_A3: op_b = ipi_pkg::KBlendHi;
      default:         op_b = $signed({1'b0, cmd.ms});
    endcase
    prod_full = op_a * op_b;
    pabs      = prod[65] ? -prod : prod;
    den       = ipi_pkg::job_den(job);
    recip     = ipi_pkg::job_recip(job);
    dx        = {rem, nmag[63:48]};
    dprod     = 45'(dx) * 45'(recip);
    qe        = 16'(dprod >> ipi_pkg::RecipShift);
    dr        = dx - 29'(qest) * 29'(den);
    if (dr >= 29'(den)) begin
      qd = qest + 16'd1;
      rd = 13'(dr - 29'(den));
    end else begin
      qd = qest;
      rd = dr[12:0];
    end
    qs = neg ? -$signed(quot) : $signed(quot);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ipi_pkg::L_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ipi_pkg::L_IDLE: begin
        if (cmd.scale_go)    state_next = ipi_pkg::L_SMUL;
        else if (cmd.upd_go) state_next = ipi_pkg::L_ACC;
      end
      ipi_pkg::L_SMUL: state_next = ipi_pkg::L_SRND;
      ipi_pkg::L_SRND: state_next = ipi_pkg::L_IDLE;
      ipi_pkg::L_ACC:  state_next = cmd.started ? ipi_pkg::L_SQ : ipi_pkg::L_IDLE;
      ipi_pkg::L_SQ:   state_next = ipi_pkg::L_MUL;
      ipi_pkg::L_MUL:  state_next = ipi_pkg::L_DLD;
      ipi_pkg::L_DLD:  state_next = ipi_pkg::L_DIV;
      ipi_pkg::L_DIV:  if (cnt == 3'd7) state_next = ipi_pkg::L_WB;
      ipi_pkg::L_WB: begin
        state_next = (job == ipi_pkg::JOB_VEL) ? ipi_pkg::L_IDLE : ipi_pkg::L_MUL;
      end
      default: state_next = ipi_pkg::L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.scl_done <= (state == ipi_pkg::L_SRND);
      stat.upd_done <= (state == ipi_pkg::L_ACC && !cmd.started) ||
                       (state == ipi_pkg::L_WB && job == ipi_pkg::JOB_VEL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accel <= '0;
      drive      <= '0;
      vel        <= '0;
      pos        <= '0;
      job        <= ipi_pkg::JOB_A2;
    end else begin
      case (state)
        ipi_pkg::L_SMUL: prod_s <= raw * $signed({1'b0, scale});
        ipi_pkg::L_SRND: a_scl <= ipi_pkg::sat32(ipi_pkg::rsh_rnd(64'(prod_s),
                                                                 ipi_pkg::ScaleShift));
        ipi_pkg::L_ACC: begin
          last_accel <= acc_now;
          diff       <= diff_now;
        end
        ipi_pkg::L_SQ: begin
          sq  <= dmag * dmag;
          job <= ipi_pkg::JOB_A2;
        end
        ipi_pkg::L_MUL: prod <= prod_full;
        ipi_pkg::L_DLD: begin
          neg  <= prod[65];
          nmag <= pabs[63:0] + 64'(den >> 1);
          rem  <= '0;
          quot <= '0;
          cnt  <= '0;
        end
        ipi_pkg::L_DIV: begin
          if (!cnt[0]) begin
            qest <= qe;
          end else begin
            nmag <= {nmag[47:0], 16'd0};
            quot <= {quot[47:0], qd};
            rem  <= rd;
          end
          cnt <= cnt + 3'd1;
        end
        ipi_pkg::L_WB: begin
          case (job)
            ipi_pkg::JOB_A2:  a2  <= 34'(64'(drive) + qs);
            ipi_pkg::JOB_A3:  a3  <= 34'(64'(drive) + qs);
            ipi_pkg::JOB_V2:  v2  <= ipi_pkg::sat48(64'(vel) + qs);
            ipi_pkg::JOB_V3:  v3  <= ipi_pkg::sat48(64'(vel) + qs);
            ipi_pkg::JOB_V4:  v4  <= ipi_pkg::sat48(64'(vel) + qs);
            ipi_pkg::JOB_POS: pos <= ipi_pkg::sat48(64'(pos) + qs);
            default: begin
              vel   <= ipi_pkg::sat48(64'(vel) + qs);
              drive <= diff;
            end
          endcase
          job <= ipi_pkg::job_after(job);
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/ipi_rot.sv @@
`default_nettype none
module ipi_rot (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [31:0] a [3],
  input  logic signed [15:0] q [4],
  output logic signed [31:0] r [3],
  output logic               done
);

  ipi_pkg::rot_state_t state, state_next;
  logic [1:0]          cnt;
  logic signed [55:0]  acc [4];
  logic signed [36:0]  t [4];
  logic signed [36:0]  ma [4];
  logic signed [15:0]  mb [4];
  logic                mneg [4];
  logic signed [52:0]  p [4];
  logic signed [63:0]  t_rnd [4];
  logic signed [31:0]  r_rnd [3];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ma[j]   = '0;
      mb[j]   = '0;
      mneg[j] = 1'b0;
    end
    if (state == ipi_pkg::ROT_T) begin
      case (cnt)
        2'd0: begin
          ma[0] = 37'(a[0]); mb[0] = q[1]; mneg[0] = 1'b1;
          ma[1] = 37'(a[0]); mb[1] = q[0];
          ma[2] = 37'(a[1]); mb[2] = q[0];
          ma[3] = 37'(a[2]); mb[3] = q[0];
        end
        2'd1: begin
          ma[0] = 37'(a[1]); mb[0] = q[2]; mneg[0] = 1'b1;
          ma[1] = 37'(a[2]); mb[1] = q[2];
          ma[2] = 37'(a[0]); mb[2] = q[3];
          ma[3] = 37'(a[1]); mb[3] = q[1];
        end
        default: begin
          ma[0] = 37'(a[2]); mb[0] = q[3]; mneg[0] = 1'b1;
          ma[1] = 37'(a[1]); mb[1] = q[3]; mneg[1] = 1'b1;
          ma[2] = 37'(a[2]); mb[2] = q[1]; mneg[2] = 1'b1;
          ma[3] = 37'(a[0]); mb[3] = q[2]; mneg[3] = 1'b1;
        end
      endcase
    end else if (state == ipi_pkg::ROT_R) begin
      case (cnt)
        2'd0: begin
          ma[0] = t[0]; mb[0] = q[1]; mneg[0] = 1'b1;
          ma[1] = t[0]; mb[1] = q[2]; mneg[1] = 1'b1;
          ma[2] = t[0]; mb[2] = q[3]; mneg[2] = 1'b1;
        end
        2'd1: begin
          ma[0] = t[1]; mb[0] = q[0];
          ma[1] = t[2]; mb[1] = q[0];
          ma[2] = t[3]; mb[2] = q[0];
        end
        2'd2: begin
          ma[0] = t[2]; mb[0] = q[3]; mneg[0] = 1'b1;
          ma[1] = t[3]; mb[1] = q[1]; mneg[1] = 1'b1;
          ma[2] = t[1]; mb[2] = q[2]; mneg[2] = 1'b1;
        end
        default: begin
          ma[0] = t[3]; mb[0] = q[2];
          ma[1] = t[1]; mb[1] = q[3];
          ma[2] = t[2]; mb[2] = q[1];
        end
      endcase
    end
    for (int j = 0; j < 4; j++) begin
      p[j]     = ma[j] * mb[j];
      t_rnd[j] = ipi_pkg::rsh_rnd(64'(acc[j]), ipi_pkg::QuatFrac);
    end
    for (int j = 0; j < 3; j++) r_rnd[j] = ipi_pkg::sat32(t_rnd[j]);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ipi_pkg::ROT_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ipi_pkg::ROT_IDLE: if (go) state_next = ipi_pkg::ROT_T;
      ipi_pkg::ROT_T:    if (cnt == 2'd2) state_next = ipi_pkg::ROT_TRND;
      ipi_pkg::ROT_TRND: state_next = ipi_pkg::ROT_R;
      ipi_pkg::ROT_R:    if (cnt == 2'd3) state_next = ipi_pkg::ROT_RRND;
      ipi_pkg::ROT_RRND: state_next = ipi_pkg::ROT_IDLE;
      default:           state_next = ipi_pkg::ROT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= (state == ipi_pkg::ROT_RRND);
      case (state)
        ipi_pkg::ROT_IDLE: begin
          cnt <= '0;
          for (int j = 0; j < 4; j++) acc[j] <= '0;
        end
        ipi_pkg::ROT_T, ipi_pkg::ROT_R: begin
          cnt <= cnt + 2'd1;
          for (int j = 0; j < 4; j++) begin
            acc[j] <= acc[j] + (mneg[j] ? -56'(p[j]) : 56'(p[j]));
          end
        end
        ipi_pkg::ROT_TRND: begin
          cnt <= '0;
          for (int j = 0; j < 4; j++) begin
            t[j]   <= t_rnd[j][36:0];
            acc[j] <= '0;
          end
        end
        ipi_pkg::ROT_RRND: begin
          for (int j = 0; j < 3; j++) r[j] <= r_rnd[j];
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/ipi_merge.sv @@
`default_nettype none
module ipi_merge (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [63:0] sq [3],
  input  logic [20:0] thr,
  output logic        still
);

  logic [65:0] norm;
  logic [41:0] thr2;

  always_comb begin
    norm = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
    thr2 = thr * thr;
  end

  always_ff @(posedge clk) begin
    if (rst)     still <= 1'b1;
    else if (en) still <= (norm < 66'(thr2));
  end

endmodule
`default_nettype wire

@@ sv/imu_position_integrator_rk4.sv @@
`default_nettype none
// A sample that only records time and acceleration goes from accept to result without
// integrating; an integrating sample makes seven passes per lane through the constant
// divider, which yields 16 quotient bits per step.
// One sample is in work at a time; the next can be taken on the edge after its result
// is loaded. Reset clears position, velocity and history, sets the merge stage's
// stationary flag and loads the register defaults; no clearing pass is needed.
module imu_position_integrator_rk4 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] acc_x,
  input  logic signed [15:0] acc_y,
  input  logic signed [15:0] acc_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic [31:0]        time_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [47:0] pos_z,
  output logic               stationary,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [23:0]         acc_scale;
  logic signed [21:0]  grav [3];
  logic [20:0]         still_threshold;

  ipi_pkg::top_state_t state, state_next;
  ipi_pkg::lane_cmd_t  cmd, cmd_next;
  logic                rot_go, rot_go_next, rot_done;
  logic                merge_en, load_out, still;
  logic [31:0]         last_time, tnow, elapsed;
  logic [15:0]         ms_now;
  logic signed [15:0]  raw [3];
  logic signed [15:0]  qv [4];
  logic signed [31:0]  a_scl [3];
  logic signed [31:0]  rot_r [3];
  logic [63:0]         sq [3];
  logic signed [47:0]  pos_l [3];
  ipi_pkg::lane_stat_t stat [3];
  logic                scl_all, upd_all;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_scale       <= ipi_pkg::AccScaleRst;
      grav[0]         <= ipi_pkg::GravXRst;
      grav[1]         <= ipi_pkg::GravYRst;
      grav[2]         <= ipi_pkg::GravZRst;
      still_threshold <= ipi_pkg::StillRst;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        ipi_pkg::REG_ACC_SCALE: acc_scale       <= pwdata[23:0];
        ipi_pkg::REG_GRAV_X:    grav[0]         <= pwdata[21:0];
        ipi_pkg::REG_GRAV_Y:    grav[1]         <= pwdata[21:0];
        ipi_pkg::REG_GRAV_Z:    grav[2]         <= pwdata[21:0];
        ipi_pkg::REG_STILL:     still_threshold <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ipi_pkg::REG_ACC_SCALE: prdata = 32'(acc_scale);
      ipi_pkg::REG_GRAV_X:    prdata = 32'(unsigned'(grav[0]));
      ipi_pkg::REG_GRAV_Y:    prdata = 32'(unsigned'(grav[1]));
      ipi_pkg::REG_GRAV_Z:    prdata = 32'(unsigned'(grav[2]));
      ipi_pkg::REG_STILL:     prdata = 32'(still_threshold);
      default:                prdata = '0;
    endcase
  end

  assign in_stall = (state != ipi_pkg::T_IDLE);
  assign scl_all  = stat[0].scl_done & stat[1].scl_done & stat[2].scl_done;
  assign upd_all  = stat[0].upd_done & stat[1].upd_done & stat[2].upd_done;
  assign elapsed  = tnow - last_time;
  assign ms_now   = (elapsed > 32'(ipi_pkg::MaxDtMs)) ? 16'(ipi_pkg::MaxDtMs) : elapsed[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ipi_pkg::T_IDLE;
      cmd    <= '0;
      rot_go <= 1'b0;
    end else begin
      state  <= state_next;
      cmd    <= cmd_next;
      rot_go <= rot_go_next;
    end
  end

  always_comb begin
    state_next        = state;
    cmd_next          = cmd;
    cmd_next.scale_go = 1'b0;
    cmd_next.upd_go   = 1'b0;
    rot_go_next       = 1'b0;
    merge_en          = 1'b0;
    load_out          = 1'b0;
    unique case (state)
      ipi_pkg::T_IDLE: begin
        if (in_valid) begin
          state_next        = ipi_pkg::T_SCALE;
          cmd_next.scale_go = 1'b1;
        end
      end
      ipi_pkg::T_SCALE: begin
        if (scl_all) begin
          state_next  = ipi_pkg::T_ROT;
          rot_go_next = 1'b1;
        end
      end
      ipi_pkg::T_ROT: begin
        if (rot_done) begin
          state_next       = ipi_pkg::T_UPD;
          cmd_next.upd_go  = 1'b1;
          cmd_next.started = (last_time != 32'd0);
          cmd_next.ms      = ms_now;
        end
      end
      ipi_pkg::T_UPD: begin
        if (upd_all) begin
          state_next = ipi_pkg::T_DONE;
          merge_en   = cmd.started;
        end
      end
      ipi_pkg::T_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ipi_pkg::T_IDLE;
          load_out   = 1'b1;
        end
      end
      default: state_next = ipi_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ipi_pkg::T_IDLE && in_valid) begin
      raw[0] <= acc_x;
      raw[1] <= acc_y;
      raw[2] <= acc_z;
      qv[0]  <= quat_w;
      qv[1]  <= quat_x;
      qv[2]  <= quat_y;
      qv[3]  <= quat_z;
      tnow   <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)                                        last_time <= '0;
    else if (state == ipi_pkg::T_ROT && rot_done)   last_time <= tnow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pos_x      <= cmd.started ? pos_l[0] : '0;
      pos_y      <= cmd.started ? pos_l[1] : '0;
      pos_z      <= cmd.started ? pos_l[2] : '0;
      stationary <= still;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ipi_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .raw   (raw[i]),
      .scale (acc_scale),
      .grav  (grav[i]),
      .rot   (rot_r[i]),
      .stat  (stat[i]),
      .a_scl (a_scl[i]),
      .sq    (sq[i]),
      .pos   (pos_l[i])
    );
  end

  ipi_rot u_rot (
    .clk  (clk),
    .rst  (rst),
    .go   (rot_go),
    .a    (a_scl),
    .q    (qv),
    .r    (rot_r),
    .done (rot_done)
  );

  ipi_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .en    (merge_en),
    .sq    (sq),
    .thr   (still_threshold),
    .still (still)
  );

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    (stat[0] == stat[1]) && (stat[1] == stat[2]))
    else $error("lanes out of step");

  a_rot_done_state: assert property (@(posedge clk) disable iff (rst)
    rot_done |-> state == ipi_pkg::T_ROT)
    else $error("rotation finished outside its phase");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ipi_pkg::T_DONE)
    else $error("result loaded outside the done phase");

endmodule
`default_nettype wire
